[sv/gelu_tanh_approx_unit_macros.svh]
// Assertion macros for the GELU tanh approximation unit.
// Used by the top level; expects signals named clk and rst_n in scope.
`ifndef GELU_TANH_APPROX_UNIT_MACROS_SVH
`define GELU_TANH_APPROX_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define GTA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define GTA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/gta_pkg.sv]
// Shared types and constants for the GELU tanh approximation unit.
// No dependencies; used by all RTL modules through scoped names.
`default_nettype none

package gta_pkg;

  // Q.24 unsigned fixed point
  localparam int QB = 24;
  localparam logic [24:0] QONE = 25'h1000000;
  localparam logic [27:0] A_LIMIT = 28'h8000000;   // 8.0 in Q.24
  localparam logic [25:0] DEN_MAX = 26'h2000000;   // 2.0 in Q.24

  // Scaled constants
  localparam logic [19:0] K_CUBE  = 20'd750193;    // 0.044715
  localparam logic [24:0] K_TWOZ  = 25'd26772563;  // 2 * sqrt(2/pi)
  localparam logic [24:0] K_LOG2E = 25'd24204406;  // log2(e)
  localparam logic [23:0] K_LN2   = 24'd11629080;  // ln(2)

  // Exponential series and reciprocal divider
  localparam int SERIES_ORDER = 7;
  localparam int RECIP_SHIFT  = 28;
  localparam int QUO_W        = 25;
  localparam logic [25:0] REM_INIT = 26'h0800000; // top numerator bits, 2^23

  // Per-sample sideband carried alongside the datapath
  typedef struct packed {
    logic        vld;
    logic        neg;
    logic [16:0] ax;
    logic        last;
  } tag_t;

  // Lane through the exponential series cells
  typedef struct packed {
    tag_t        tag;
    logic [23:0] w;
    logic [6:0]  n;
    logic [24:0] p;
  } exp_lane_t;

  // Lane through the reciprocal divider cells
  typedef struct packed {
    tag_t        tag;
    logic [25:0] den;
    logic [25:0] rem;
    logic [24:0] quo;
  } div_lane_t;

endpackage

`default_nettype wire

[sv/gta_series_cell.sv]
// One Horner step of the exp series: p <= 1 - (w * p) / DIV_K, in Q.24.
// Two register stages (multiply, then reciprocal multiply). Depends on gta_pkg.
`default_nettype none

module gta_series_cell #(
  parameter int DIV_K = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gta_pkg::exp_lane_t    lane_in,
  output gta_pkg::exp_lane_t    lane_out
);

  // ceil(2^28 / k): exact floor division for dividends below 2^25
  localparam logic [28:0] RECIP =
    29'(((64'd1 << gta_pkg::RECIP_SHIFT) + 64'(DIV_K) - 64'd1) / 64'(DIV_K));

  gta_pkg::exp_lane_t a_lane_r;
  logic [23:0]        prod_r;
  logic [23:0]        prod_nxt;
  logic [48:0]        wp_full;

  gta_pkg::exp_lane_t b_lane_r;
  gta_pkg::exp_lane_t b_lane_nxt;
  logic [52:0]        q_full;
  logic [23:0]        quot;

  // Stage A: w * p, back to Q.24
  always_comb begin
    wp_full  = 49'(lane_in.w) * 49'(lane_in.p);
    prod_nxt = wp_full[47:24];
  end

  always_ff @(posedge clk) begin
    a_lane_r <= lane_in;
    prod_r   <= prod_nxt;
    if (!rst_n) begin
      a_lane_r.tag.vld <= 1'b0;
    end
  end

  // Stage B: divide by constant via reciprocal, subtract from one
  always_comb begin
    q_full       = 53'(prod_r) * 53'(RECIP);
    quot         = q_full[gta_pkg::RECIP_SHIFT +: 24];
    b_lane_nxt   = a_lane_r;
    b_lane_nxt.p = gta_pkg::QONE - 25'(quot);
  end

  always_ff @(posedge clk) begin
    b_lane_r <= b_lane_nxt;
    if (!rst_n) begin
      b_lane_r.tag.vld <= 1'b0;
    end
  end

  assign lane_out = b_lane_r;

endmodule

`default_nettype wire

[sv/gta_div_cell.sv]
// One restoring-division step of s = (2^48 + den/2) / den: one quotient bit.
// Numerator low bits come from den/2. Depends on gta_pkg.
`default_nettype none

module gta_div_cell #(
  parameter int BIT_IDX = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gta_pkg::div_lane_t    lane_in,
  output gta_pkg::div_lane_t    lane_out
);

  gta_pkg::div_lane_t lane_r;
  gta_pkg::div_lane_t lane_nxt;
  logic [24:0]        den_half;
  logic [25:0]        rem_sh;

  // Shift in next numerator bit, trial subtract
  always_comb begin
    den_half = lane_in.den[25:1];
    rem_sh   = {lane_in.rem[24:0], den_half[BIT_IDX]};
    lane_nxt = lane_in;
    if (rem_sh >= lane_in.den) begin
      lane_nxt.rem          = rem_sh - lane_in.den;
      lane_nxt.quo[BIT_IDX] = 1'b1;
    end else begin
      lane_nxt.rem = rem_sh;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
    if (!rst_n) begin
      lane_r.tag.vld <= 1'b0;
    end
  end

  assign lane_out = lane_r;

endmodule

`default_nettype wire

[sv/gelu_tanh_approx_unit.sv]
// GELU activation, tanh approximation, signed fixed point in and out.
// Depends on gta_pkg, gta_series_cell, gta_div_cell and the assertion macro header.
//
// Usage:
//   Input: drive in_x / in_last and raise start; the transaction is taken at a
//   rising edge with start high and busy low. busy is low whenever out of
//   reset, so one sample can be taken every cycle, back to back.
//   Output: out_valid is high for exactly one cycle per sample, with out_y and
//   out_last; the transaction completes at the edge that ends that cycle.
//   The receiver cannot stall, and none is needed: nothing queues.
//   Pipeline: 50 register stages. Throughput is one sample per cycle; the
//   stage count is set by the polynomial multiplies (7 stages), the exp series
//   row (7 cells of 2 stages), the e shift (1 stage), the reciprocal divider
//   row (25 cells, one quotient bit each) and the final scale and saturate
//   (3 stages).
//   Reset: synchronous, active low. All pipeline valid bits clear and busy is
//   high while reset is held; samples in flight are dropped.
`default_nettype none
`include "gelu_tanh_approx_unit_macros.svh"

module gelu_tanh_approx_unit #(
  parameter int FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_x,
  input  logic               in_last,
  output logic               out_valid,
  output logic signed [15:0] out_y,
  output logic               out_last
);

  localparam int A_SHIFT = gta_pkg::QB - FRAC_BITS;
  localparam int N_SER   = gta_pkg::SERIES_ORDER;
  localparam int N_DIV   = gta_pkg::QUO_W;
  localparam logic [15:0] Y_POS_MAX = 16'h7fff;
  localparam logic [15:0] Y_NEG_MAX = 16'h8000;
  localparam logic [16:0] M_POS_MAX = 17'd32767;
  localparam logic [16:0] M_NEG_MAX = 17'd32768;
  localparam logic [41:0] M_ROUND   = 42'h0000800000;

  logic accept;

  // Stage 1: magnitude and clamped Q.24 argument
  logic [15:0]   x_u;
  logic [16:0]   ax;
  logic [33:0]   a_sh;
  gta_pkg::tag_t t1_r;
  gta_pkg::tag_t t1_nxt;
  logic [27:0]   a1_r;
  logic [27:0]   a1_nxt;

  // Stages 2..7: polynomial and exponent split
  gta_pkg::tag_t t2_r, t3_r, t4_r, t5_r, t6_r;
  logic [27:0]   a2a_r, a3a_r;
  logic [55:0]   sq_full;
  logic [30:0]   sq_r;
  logic [58:0]   cube_full;
  logic [33:0]   cube_r;
  logic [53:0]   cterm_full;
  logic [28:0]   poly_r;
  logic [28:0]   poly_nxt;
  logic [53:0]   u_full;
  logic [29:0]   u_r;
  logic [54:0]   v_full;
  logic [6:0]    n6_r;
  logic [23:0]   f6_r;
  logic [47:0]   w_full;
  gta_pkg::exp_lane_t e0_r;
  gta_pkg::exp_lane_t e0_nxt;

  // Cell rows
  gta_pkg::exp_lane_t ex [N_SER+1];
  gta_pkg::div_lane_t dv [N_DIV+1];
  gta_pkg::div_lane_t d0_r;
  gta_pkg::div_lane_t d0_nxt;
  logic [24:0]        e_val;

  // Final stages
  gta_pkg::tag_t g_tag_r;
  logic [24:0]   g_r;
  logic [24:0]   g_nxt;
  logic [24:0]   s_clamp;
  gta_pkg::tag_t m_tag_r;
  logic [16:0]   m_r;
  logic [41:0]   m_full;
  gta_pkg::tag_t o_tag_r;
  logic [15:0]   out_y_r;
  logic [15:0]   out_y_nxt;
  logic [16:0]   neg_m;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // Stage 1
  always_comb begin
    x_u    = in_x;
    ax     = x_u[15] ? 17'(17'h10000 - 17'(x_u)) : 17'(x_u);
    a_sh   = 34'(ax) << A_SHIFT;
    a1_nxt = (a_sh > 34'(gta_pkg::A_LIMIT)) ? gta_pkg::A_LIMIT : a_sh[27:0];
    t1_nxt.vld  = accept;
    t1_nxt.neg  = x_u[15];
    t1_nxt.ax   = ax;
    t1_nxt.last = in_last;
  end

  always_ff @(posedge clk) begin
    t1_r <= t1_nxt;
    a1_r <= a1_nxt;
    if (!rst_n) begin
      t1_r.vld <= 1'b0;
    end
  end

  // Polynomial products
  always_comb begin
    sq_full    = 56'(a1_r) * 56'(a1_r);
    cube_full  = 59'(sq_r) * 59'(a2a_r);
    cterm_full = 54'(cube_r) * 54'(gta_pkg::K_CUBE);
    poly_nxt   = 29'(30'(a3a_r) + cterm_full[53:24]);
    u_full     = 54'(poly_r) * 54'(gta_pkg::K_TWOZ);
    v_full     = 55'(u_r) * 55'(gta_pkg::K_LOG2E);
    w_full     = 48'(f6_r) * 48'(gta_pkg::K_LN2);
    e0_nxt.tag = t6_r;
    e0_nxt.w   = w_full[47:24];
    e0_nxt.n   = n6_r;
    e0_nxt.p   = gta_pkg::QONE;
  end

  always_ff @(posedge clk) begin
    // x^2, x^3
    t2_r   <= t1_r;
    sq_r   <= sq_full[54:24];
    a2a_r  <= a1_r;
    t3_r   <= t2_r;
    cube_r <= cube_full[57:24];
    a3a_r  <= a2a_r;
    // x + c*x^3, scale to 2z, convert to base 2
    t4_r   <= t3_r;
    poly_r <= poly_nxt;
    t5_r   <= t4_r;
    u_r    <= u_full[53:24];
    t6_r   <= t5_r;
    n6_r   <= v_full[54:48];
    f6_r   <= v_full[47:24];
    // fractional part back to natural base, seed series
    e0_r   <= e0_nxt;
    if (!rst_n) begin
      t2_r.vld   <= 1'b0;
      t3_r.vld   <= 1'b0;
      t4_r.vld   <= 1'b0;
      t5_r.vld   <= 1'b0;
      t6_r.vld   <= 1'b0;
      e0_r.tag.vld <= 1'b0;
    end
  end

  // Exp series row: highest order term first
  assign ex[0] = e0_r;

  for (genvar gi = 0; gi < N_SER; gi++) begin : g_series
    gta_series_cell #(
      .DIV_K (N_SER - gi)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .lane_in  (ex[gi]),
      .lane_out (ex[gi+1])
    );
  end

  // Integer part of exponent: shift, then form 1 + e
  always_comb begin
    e_val      = ex[N_SER].p >> ex[N_SER].n;
    d0_nxt.tag = ex[N_SER].tag;
    d0_nxt.den = 26'(gta_pkg::QONE) + 26'(e_val);
    d0_nxt.rem = gta_pkg::REM_INIT;
    d0_nxt.quo = '0;
  end

  always_ff @(posedge clk) begin
    d0_r <= d0_nxt;
    if (!rst_n) begin
      d0_r.tag.vld <= 1'b0;
    end
  end

  // Reciprocal divider row, MSB of quotient first
  assign dv[0] = d0_r;

  for (genvar gj = 0; gj < N_DIV; gj++) begin : g_div
    gta_div_cell #(
      .BIT_IDX (N_DIV - 1 - gj)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .lane_in  (dv[gj]),
      .lane_out (dv[gj+1])
    );
  end

  // Sigmoid factor with odd symmetry for negative inputs
  always_comb begin
    s_clamp = (dv[N_DIV].quo > gta_pkg::QONE) ? gta_pkg::QONE : dv[N_DIV].quo;
    g_nxt   = dv[N_DIV].tag.neg ? (gta_pkg::QONE - s_clamp) : s_clamp;
  end

  // Scale magnitude, rounded half up
  assign m_full = 42'(g_tag_r.ax) * 42'(g_r) + M_ROUND;

  // Apply sign and saturate
  always_comb begin
    neg_m = 17'(17'd0 - m_r);
    if (m_tag_r.neg) begin
      out_y_nxt = (m_r > M_NEG_MAX) ? Y_NEG_MAX : neg_m[15:0];
    end else begin
      out_y_nxt = (m_r > M_POS_MAX) ? Y_POS_MAX : m_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    g_tag_r <= dv[N_DIV].tag;
    g_r     <= g_nxt;
    m_tag_r <= g_tag_r;
    m_r     <= m_full[40:24];
    o_tag_r <= m_tag_r;
    out_y_r <= out_y_nxt;
    if (!rst_n) begin
      g_tag_r.vld <= 1'b0;
      m_tag_r.vld <= 1'b0;
      o_tag_r.vld <= 1'b0;
    end
  end

  // m_tag_r is one stage behind g_tag_r, so m_r pairs with it
  assign out_valid = o_tag_r.vld;
  assign out_y     = out_y_r;
  assign out_last  = o_tag_r.last;

  // Checks
  `GTA_ASSERT_NXT(a_capture, accept,
    t1_r.vld && (t1_r.last == $past(in_last)), "input transaction not captured")
  `GTA_ASSERT_IMP(a_series_bound, ex[N_SER].tag.vld,
    ex[N_SER].p <= gta_pkg::QONE, "series result above one")
  `GTA_ASSERT_IMP(a_den_range, d0_r.tag.vld,
    (d0_r.den >= 26'(gta_pkg::QONE)) && (d0_r.den <= gta_pkg::DEN_MAX),
    "divisor out of range")
  `GTA_ASSERT_IMP(a_quo_bound, dv[N_DIV].tag.vld,
    dv[N_DIV].quo <= gta_pkg::QONE, "reciprocal above one")
  `GTA_ASSERT_IMP(a_sign_pos, out_valid && !o_tag_r.neg,
    !out_y[15], "negative result for positive input")
  `GTA_ASSERT_IMP(a_sign_neg, out_valid && o_tag_r.neg,
    out_y[15] || (out_y == 16'sd0), "positive result for negative input")

endmodule

`default_nettype wire
